[hdl/disc_track_layout_core_assert.svh]
// Assertion macros shared by the disc track layout RTL.
`ifndef DISC_TRACK_LAYOUT_CORE_ASSERT_SVH
`define DISC_TRACK_LAYOUT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define DTL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define DTL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DTL_ASSERT_IMP(label, ante, cons, msg)
`define DTL_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[hdl/dtl_pkg.sv]
// Package with constants and types of the disc track layout block.
`timescale 1ns / 1ps
package dtl_pkg;

    localparam int unsigned TRACK_PADDING     = 4;
    localparam int unsigned LEAD_IN_FRAMES    = 150;
    localparam logic [15:0] FRAME_BYTES_RESET = 16'd2448;

    // One track descriptor as held in the input stage.
    typedef struct packed {
        logic [23:0] frame_count;
        logic [15:0] pregap_frames;
        logic [15:0] postgap_frames;
        logic [15:0] pad_frames;
        logic        pregap_stored;
        logic        first_track;
    } trk_t;

    // Sector results and stream frame totals handed to the byte stage.
    typedef struct packed {
        logic [31:0] start_sector;
        logic [31:0] end_sector;
        logic [31:0] frames_before;
        logic [31:0] frames_after;
    } lay_t;

endpackage

[hdl/disc_track_layout_core.sv]
// Top level of the disc track layout block: sector and stream byte layout per track.
//
//  channel  | handshake          | direction | word
//  ---------+--------------------+-----------+-------------------------------------------
//  input    | in_valid/in_ready  | in        | one track descriptor
//  output   | out_valid/out_ready| out       | sectors and stream byte offsets of a track
//  config   | cfg_we             | in        | frame_bytes, written with no wait
//
// A word passes three register stages (input, sector layout, byte output); out_valid rises
// as the word enters the output stage. One word is accepted every cycle unless a stall
// holds the stages; running sums update as a word leaves the input stage. Reset clears the
// running sums, the lead-in shift and all valid flags, and sets frame_bytes to 2448.
// A stall on the output fills the stages behind it before in_ready drops.
`timescale 1ns / 1ps
`include "disc_track_layout_core_assert.svh"
module disc_track_layout_core
    import dtl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] frame_count,
    input  logic [15:0] pregap_frames,
    input  logic [15:0] postgap_frames,
    input  logic [15:0] pad_frames,
    input  logic        pregap_stored,
    input  logic        first_track,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] start_sector,
    output logic [31:0] end_sector,
    output logic [47:0] stream_byte_location,
    output logic [47:0] total_stream_bytes
);

    logic [15:0] frame_bytes_reg;
    logic [31:0] logical_offset_reg, logical_offset_next;
    logic [31:0] stream_frame_total_reg, stream_frame_total_next;
    logic [7:0]  lead_in_shift_reg, lead_in_shift_next;

    logic        in_vld_reg;
    trk_t        in_trk_reg;
    logic        mid_vld_reg;
    lay_t        mid_reg, mid_next;
    logic        out_vld_reg;
    logic [31:0] out_start_reg, out_end_reg;
    logic [47:0] out_loc_reg, out_total_reg;

    logic out_free, mid_free, in_free, in_adv;

    // Layout stage signals.
    logic [31:0] off_base, frm_base, start, rep_start;
    logic [23:0] log_frames;
    logic [7:0]  shift;
    logic [33:0] end_pos, end_diff;
    logic [16:0] end_neg;
    logic [24:0] frames_p3, padded;
    logic [47:0] loc_prod, total_prod;

    assign out_free = !out_vld_reg || out_ready;
    assign mid_free = !mid_vld_reg || out_free;
    assign in_free  = !in_vld_reg || mid_free;
    assign in_adv   = in_vld_reg && mid_free;
    assign in_ready = in_free;

    always_comb
    begin
        off_base = in_trk_reg.first_track ? 32'd0 : logical_offset_reg;
        frm_base = in_trk_reg.first_track ? 32'd0 : stream_frame_total_reg;
        start    = in_trk_reg.pregap_stored ? off_base
                                            : off_base + {16'd0, in_trk_reg.pregap_frames};

        // A first track loses a nonzero unstored pregap shorter than the track from its length.
        log_frames = in_trk_reg.frame_count;
        if (in_trk_reg.first_track && !in_trk_reg.pregap_stored
            && (in_trk_reg.pregap_frames != 16'd0)
            && (in_trk_reg.frame_count > {8'd0, in_trk_reg.pregap_frames}))
        begin
            log_frames = in_trk_reg.frame_count - {8'd0, in_trk_reg.pregap_frames};
        end

        lead_in_shift_next = lead_in_shift_reg;
        if (in_trk_reg.first_track)
        begin
            if (start < 32'(LEAD_IN_FRAMES))
            begin
                lead_in_shift_next = 8'(LEAD_IN_FRAMES) - start[7:0];
            end
            else
            begin
                lead_in_shift_next = 8'd0;
            end
        end
        shift = lead_in_shift_next;

        // Signed end sector as a nonnegative sum minus a nonnegative amount, then clamped.
        end_pos  = {2'd0, start} + {10'd0, log_frames} + {26'd0, shift};
        end_neg  = (log_frames != 24'd0) ? ({1'b0, in_trk_reg.pad_frames} + 17'd1) : 17'd0;
        end_diff = end_pos - {17'd0, end_neg};

        rep_start = start + {24'd0, shift};
        if (in_trk_reg.first_track && (start <= 32'(LEAD_IN_FRAMES)))
        begin
            rep_start = 32'd0;
        end

        frames_p3 = {1'b0, in_trk_reg.frame_count} + 25'd3;
        padded    = {frames_p3[24:2], 2'b00};

        logical_offset_next     = start + {16'd0, in_trk_reg.postgap_frames}
                                  + {8'd0, in_trk_reg.frame_count};
        stream_frame_total_next = frm_base + {7'd0, padded};

        mid_next.start_sector = rep_start;
        if (end_pos < {17'd0, end_neg})
        begin
            mid_next.end_sector = 32'd0;
        end
        else if (end_diff[33:32] != 2'd0)
        begin
            mid_next.end_sector = 32'hFFFF_FFFF;
        end
        else
        begin
            mid_next.end_sector = end_diff[31:0];
        end
        mid_next.frames_before = frm_base;
        mid_next.frames_after  = stream_frame_total_next;
    end

    assign loc_prod   = {16'd0, mid_reg.frames_before} * {32'd0, frame_bytes_reg};
    assign total_prod = {16'd0, mid_reg.frames_after} * {32'd0, frame_bytes_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bytes_reg        <= FRAME_BYTES_RESET;
            logical_offset_reg     <= 32'd0;
            stream_frame_total_reg <= 32'd0;
            lead_in_shift_reg      <= 8'd0;
            in_vld_reg             <= 1'b0;
            mid_vld_reg            <= 1'b0;
            out_vld_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                frame_bytes_reg <= cfg_wdata;
            end
            if (in_adv)
            begin
                logical_offset_reg     <= logical_offset_next;
                stream_frame_total_reg <= stream_frame_total_next;
                lead_in_shift_reg      <= lead_in_shift_next;
            end
            if (in_free)
            begin
                in_vld_reg <= in_valid;
            end
            if (mid_free)
            begin
                mid_vld_reg <= in_vld_reg;
            end
            if (out_free)
            begin
                out_vld_reg <= mid_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && in_valid)
        begin
            in_trk_reg.frame_count    <= frame_count;
            in_trk_reg.pregap_frames  <= pregap_frames;
            in_trk_reg.postgap_frames <= postgap_frames;
            in_trk_reg.pad_frames     <= pad_frames;
            in_trk_reg.pregap_stored  <= pregap_stored;
            in_trk_reg.first_track    <= first_track;
        end
        if (in_adv)
        begin
            mid_reg <= mid_next;
        end
        if (out_free && mid_vld_reg)
        begin
            out_start_reg <= mid_reg.start_sector;
            out_end_reg   <= mid_reg.end_sector;
            out_loc_reg   <= loc_prod;
            out_total_reg <= total_prod;
        end
    end

    assign out_valid            = out_vld_reg;
    assign start_sector         = out_start_reg;
    assign end_sector           = out_end_reg;
    assign stream_byte_location = out_loc_reg;
    assign total_stream_bytes   = out_total_reg;

    `DTL_ASSERT_IMP(a_in_blocked, in_vld_reg && !mid_free, !in_ready, "accepted while blocked")
    `DTL_ASSERT_NXT(a_mid_held, !mid_free, mid_vld_reg && $stable(mid_reg), "stalled word lost")
    `DTL_ASSERT_NXT(a_shift_range, in_adv, lead_in_shift_reg <= 8'(LEAD_IN_FRAMES), "bad shift")
    `DTL_ASSERT_IMP(a_pad, mid_vld_reg, mid_reg.frames_after[1:0] == mid_reg.frames_before[1:0], "no pad")

endmodule

[bench/disc_track_layout_core_test.sv]
// Self-checking testbench for disc_track_layout_core: directed and random track streams.
`timescale 1ns / 1ps
module disc_track_layout_core_test
    import dtl_pkg::*;
();

    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     DRAIN_CYCLES = 6;
    localparam longint SECTOR_MAX   = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] start_sector;
        logic [31:0] end_sector;
        logic [47:0] stream_byte_location;
        logic [47:0] total_stream_bytes;
    } track_layout_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_we         = 1'b0;
    logic [15:0] cfg_wdata      = '0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [23:0] frame_count    = '0;
    logic [15:0] pregap_frames  = '0;
    logic [15:0] postgap_frames = '0;
    logic [15:0] pad_frames     = '0;
    logic        pregap_stored  = 1'b0;
    logic        first_track    = 1'b0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [31:0] start_sector;
    logic [31:0] end_sector;
    logic [47:0] stream_byte_location;
    logic [47:0] total_stream_bytes;

    // Running layout of the disc as the block should hold it.
    logic [31:0] sector_cursor    = '0;
    logic [31:0] stream_frames    = '0;
    logic [7:0]  lead_in          = '0;
    logic [15:0] frame_size_bytes = FRAME_BYTES_RESET;

    track_layout_t pending_layouts[$];
    int            mismatches    = 0;
    int            cycle_count   = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    disc_track_layout_core dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .frame_count          (frame_count),
        .pregap_frames        (pregap_frames),
        .postgap_frames       (postgap_frames),
        .pad_frames           (pad_frames),
        .pregap_stored        (pregap_stored),
        .first_track          (first_track),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .start_sector         (start_sector),
        .end_sector           (end_sector),
        .stream_byte_location (stream_byte_location),
        .total_stream_bytes   (total_stream_bytes)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Advances the running disc layout by one track and returns what the block must report.
    function automatic track_layout_t layout_track(input trk_t t);
        track_layout_t r;
        logic [31:0]   track_start;
        logic [31:0]   log_frames;
        logic [31:0]   padded;
        longint        last_sector;
        longint        span;
        longint        pad;
        if (t.first_track)
        begin
            sector_cursor = '0;
            stream_frames = '0;
        end
        if (!t.pregap_stored)
            sector_cursor = sector_cursor + 32'(t.pregap_frames);
        track_start = sector_cursor;

        log_frames = 32'(t.frame_count);
        if (t.first_track && !t.pregap_stored && t.pregap_frames != 0
            && 32'(t.frame_count) > 32'(t.pregap_frames))
            log_frames = 32'(t.frame_count) - 32'(t.pregap_frames);

        if (t.first_track)
            lead_in = (track_start < LEAD_IN_FRAMES) ? 8'(LEAD_IN_FRAMES - track_start) : 8'd0;

        last_sector = track_start;
        last_sector = last_sector + lead_in;
        if (log_frames != 0)
        begin
            span = log_frames;
            pad = t.pad_frames;
            last_sector = last_sector + span - 1 - pad;
        end
        if (last_sector < 0)
            last_sector = 0;
        if (last_sector > SECTOR_MAX)
            last_sector = SECTOR_MAX;
        r.end_sector = last_sector[31:0];

        r.start_sector = track_start + 32'(lead_in);
        if (t.first_track && track_start <= LEAD_IN_FRAMES)
            r.start_sector = '0;

        r.stream_byte_location = 48'(stream_frames) * 48'(frame_size_bytes);
        sector_cursor = sector_cursor + 32'(t.postgap_frames) + 32'(t.frame_count);
        padded = (32'(t.frame_count) + TRACK_PADDING - 1) / TRACK_PADDING * TRACK_PADDING;
        stream_frames = stream_frames + padded;
        r.total_stream_bytes = 48'(stream_frames) * 48'(frame_size_bytes);
        return r;
    endfunction

    function automatic trk_t descriptor(input logic [23:0] frames, input logic [15:0] pregap,
                                        input logic [15:0] postgap, input logic [15:0] pad,
                                        input logic stored, input logic first);
        trk_t t;
        t.frame_count    = frames;
        t.pregap_frames  = pregap;
        t.postgap_frames = postgap;
        t.pad_frames     = pad;
        t.pregap_stored  = stored;
        t.first_track    = first;
        return t;
    endfunction

    function automatic trk_t random_track(input logic first);
        trk_t t;
        case ($urandom_range(3))
            0: t.frame_count = 24'($urandom_range(4));
            1: t.frame_count = 24'($urandom_range(1, 64));
            2: t.frame_count = 24'($urandom_range(1, 300000));
            default: t.frame_count = 24'($urandom_range(24'hFFFFFF));
        endcase
        case ($urandom_range(3))
            0: t.pregap_frames = '0;
            1: t.pregap_frames = 16'(LEAD_IN_FRAMES);
            2: t.pregap_frames = 16'($urandom_range(1, 300));
            default: t.pregap_frames = 16'($urandom);
        endcase
        t.postgap_frames = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom);
        case ($urandom_range(2))
            0: t.pad_frames = '0;
            1: t.pad_frames = 16'($urandom_range(1, 8));
            default: t.pad_frames = 16'($urandom);
        endcase
        t.pregap_stored = 1'($urandom_range(1));
        t.first_track   = first;
        return t;
    endfunction

    // Returns in the time step of the acceptance edge with valid still high, so the
    // caller either sends the next word at once or lowers valid in that same step.
    task automatic send_track(input trk_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        frame_count    <= t.frame_count;
        pregap_frames  <= t.pregap_frames;
        postgap_frames <= t.postgap_frames;
        pad_frames     <= t.pad_frames;
        pregap_stored  <= t.pregap_stored;
        first_track    <= t.first_track;
        do
            @(posedge clk);
        while (!in_ready);
        pending_layouts = {pending_layouts, layout_track(t)};
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_layouts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_bytes(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        frame_size_bytes = value;
    endtask

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_layouts.size() == 0)
            begin
                $error("result word with no track pending: start_sector %0d", start_sector);
                mismatches++;
            end
            else
            begin
                track_layout_t want;
                want = pending_layouts.pop_front();
                check_field("start_sector", 48'(want.start_sector), 48'(start_sector));
                check_field("end_sector", 48'(want.end_sector), 48'(end_sector));
                check_field("stream_byte_location", want.stream_byte_location,
                            stream_byte_location);
                check_field("total_stream_bytes", want.total_stream_bytes,
                            total_stream_bytes);
            end
        end
    end

    // Tracks arriving before any first track run on from the reset state.
    task automatic test_track_before_first_disc();
        send_track(descriptor(24'd1, 16'd10, 16'd0, 16'hFFFF, 1'b0, 1'b0));
        send_track(descriptor(24'd0, 16'd0, 16'd3, 16'd5, 1'b0, 1'b0));
    endtask

    task automatic test_lead_in();
        send_track(descriptor(24'd1000, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        send_track(descriptor(24'd500, 16'd150, 16'd2, 16'd0, 1'b0, 1'b0));
        send_track(descriptor(24'd1000, 16'd150, 16'd0, 16'd0, 1'b0, 1'b1));
        send_track(descriptor(24'd100, 16'd151, 16'd0, 16'd7, 1'b0, 1'b1));
        send_track(descriptor(24'd100, 16'd100, 16'd0, 16'd0, 1'b0, 1'b1));
        send_track(descriptor(24'd0, 16'd200, 16'd0, 16'd0, 1'b1, 1'b1));
    endtask

    task automatic test_frame_rounding();
        for (int n = 0; n <= 5; n++)
            send_track(descriptor(24'(n), 16'd0, 16'd0, 16'd0, 1'b1, 1'b0));
    endtask

    task automatic test_field_extremes();
        send_track(descriptor(24'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_track(descriptor(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
        send_track(descriptor(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
    endtask

    task automatic test_frame_bytes();
        logic [15:0] settings[4];
        settings[0] = 16'd0;
        settings[1] = 16'd1;
        settings[2] = 16'hFFFF;
        settings[3] = FRAME_BYTES_RESET;
        for (int k = 0; k < 4; k++)
        begin
            wait_all_results();
            write_frame_bytes(settings[k]);
            send_track(descriptor(24'd5, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
            send_track(descriptor(24'hFFFFFF, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0));
        end
    endtask

    task automatic test_random_discs(input int track_budget);
        int   left;
        int   disc_len;
        trk_t t;
        left = track_budget;
        while (left > 0)
        begin
            disc_len = $urandom_range(1, 10);
            for (int i = 0; i < disc_len && left > 0; i++)
            begin
                t = random_track(i == 0);
                // Now and then break the disc structure with a stray or missing first track.
                if ($urandom_range(9) == 0)
                    t.first_track = 1'($urandom_range(1));
                send_track(t);
                left--;
            end
        end
    endtask

    // One long disc of near-full tracks, so both running sums wrap past 32 bits.
    task automatic test_sum_wrap(input int tracks);
        trk_t t;
        wait_all_results();
        write_frame_bytes(16'hFFFF);
        send_track(descriptor(24'hFFFFFF, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        for (int i = 1; i < tracks; i++)
        begin
            t = random_track(1'b0);
            t.frame_count = 24'($urandom_range(24'hF00000, 24'hFFFFFF));
            send_track(t);
        end
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 9;
        recv_idle_pct = 85;
        test_track_before_first_disc();
        test_lead_in();
        test_frame_rounding();
        test_field_extremes();
        test_frame_bytes();
        test_random_discs(110);

        wait_all_results();
        write_frame_bytes(16'($urandom));
        send_idle_pct = 85;
        recv_idle_pct = 9;
        test_random_discs(110);

        wait_all_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_sum_wrap(280);
        wait_all_results();
        write_frame_bytes(FRAME_BYTES_RESET);
        test_random_discs(40);
        wait_all_results();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
